@@ rtl/whp_pkg.sv @@
// ----------------------------------------------------------------------------
// whp_pkg
// Shared types and constants of the RIFF/WAVE PCM header parser.
// ----------------------------------------------------------------------------
package whp_pkg;

  // file position width, one bit above the 32-bit length so overruns show
  localparam int unsigned POS_W = 33;

  // chunk tags and form type, little-endian words as assembled
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] MIN_LENGTH = 32'd44;
  localparam logic [31:0] HDR_BYTES  = 32'd8;   // tag plus size
  localparam logic [31:0] FMT_BASE   = 32'd16;
  localparam logic [31:0] FMT_LIMIT  = 32'd64;
  localparam logic [15:0] FMT_PCM    = 16'd1;

  // first byte after the fixed fmt body, and the same less the fmt base
  localparam logic [POS_W-1:0] FMT_END      = POS_W'(36);
  localparam logic [POS_W-1:0] FMT_END_BIAS = POS_W'(20);

  // positions of the last byte of each fixed header field
  localparam logic [POS_W-1:0] OFS_RIFF_TAG  = POS_W'(3);
  localparam logic [POS_W-1:0] OFS_RIFF_SIZE = POS_W'(7);
  localparam logic [POS_W-1:0] OFS_WAVE      = POS_W'(11);
  localparam logic [POS_W-1:0] OFS_FMT_TAG   = POS_W'(15);
  localparam logic [POS_W-1:0] OFS_FMT_SIZE  = POS_W'(19);
  localparam logic [POS_W-1:0] OFS_AUDIO_FMT = POS_W'(21);
  localparam logic [POS_W-1:0] OFS_CHANNELS  = POS_W'(23);
  localparam logic [POS_W-1:0] OFS_RATE      = POS_W'(27);
  localparam logic [POS_W-1:0] OFS_BYTE_RATE = POS_W'(31);
  localparam logic [POS_W-1:0] OFS_ALIGN     = POS_W'(33);
  localparam logic [POS_W-1:0] OFS_BITS      = POS_W'(35);

  // chunk walk: distance of the previous byte from the header start, one
  // byte before the tag and size words complete
  localparam logic [POS_W-1:0] CHK_TAG_DIST  = POS_W'(2);
  localparam logic [POS_W-1:0] CHK_SIZE_DIST = POS_W'(6);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_UNSUPP    = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_HEADER = 3'b010,
    PH_CHUNKS = 3'b100
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] riff_size;
    logic [31:0] fmt_size;
    logic [15:0] chan_count;
    logic [31:0] samp_freq;
    logic [31:0] bytes_per_sec;
    logic [15:0] frame_bytes;
    logic [15:0] sample_bits;
    logic [31:0] pcm_offset;
    logic [31:0] pcm_size;
  } result_t;

endpackage

@@ rtl/whp_ifs.sv @@
// ----------------------------------------------------------------------------
// whp_ifs
// Byte input channel and result channel of the WAV header parser.
// ----------------------------------------------------------------------------
interface whp_in_if;
  logic        valid;
  logic        ready;
  logic        start_of_file;
  logic [7:0]  data_byte;
  logic [31:0] total_length;

  modport source (output valid, output start_of_file, output data_byte,
                  output total_length, input ready);
  modport sink (input valid, input start_of_file, input data_byte,
                input total_length, output ready);
endinterface

interface whp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] riff_size;
  logic [31:0] fmt_size;
  logic [15:0] chan_count;
  logic [31:0] samp_freq;
  logic [31:0] bytes_per_sec;
  logic [15:0] frame_bytes;
  logic [15:0] sample_bits;
  logic [31:0] pcm_offset;
  logic [31:0] pcm_size;

  modport source (output valid, output status, output riff_size, output fmt_size,
                  output chan_count, output samp_freq, output bytes_per_sec,
                  output frame_bytes, output sample_bits, output pcm_offset,
                  output pcm_size, input ready);
  modport sink (input valid, input status, input riff_size, input fmt_size,
                input chan_count, input samp_freq, input bytes_per_sec,
                input frame_bytes, input sample_bits, input pcm_offset,
                input pcm_size, output ready);
endinterface

@@ rtl/whp_out_buf.sv @@
// ----------------------------------------------------------------------------
// whp_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module whp_out_buf
  import whp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  result_t           push_data,
  output logic              push_ready,
  whp_out_if.source         out_ch
);

  logic    main_v_r;
  logic    skid_v_r;
  result_t main_r;
  result_t skid_r;
  logic    pop;

  assign pop        = main_v_r & out_ch.ready;
  assign push_ready = ~skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!main_v_r) begin
        main_v_r <= push_valid;
      end else if (pop) begin
        if (skid_v_r) begin
          skid_v_r <= 1'b0;
        end else begin
          main_v_r <= push_valid;
        end
      end else if (push_valid) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (!main_v_r || pop) begin
      main_r <= skid_v_r ? skid_r : push_data;
    end
    if (main_v_r && !pop && push_valid) begin
      skid_r <= push_data;
    end
  end

  assign out_ch.valid         = main_v_r;
  assign out_ch.status        = main_r.status;
  assign out_ch.riff_size     = main_r.riff_size;
  assign out_ch.fmt_size      = main_r.fmt_size;
  assign out_ch.chan_count    = main_r.chan_count;
  assign out_ch.samp_freq     = main_r.samp_freq;
  assign out_ch.bytes_per_sec = main_r.bytes_per_sec;
  assign out_ch.frame_bytes   = main_r.frame_bytes;
  assign out_ch.sample_bits   = main_r.sample_bits;
  assign out_ch.pcm_offset    = main_r.pcm_offset;
  assign out_ch.pcm_size      = main_r.pcm_size;

endmodule

@@ rtl/wav_header_parser.sv @@
// ----------------------------------------------------------------------------
// wav_header_parser
// Streaming RIFF/WAVE PCM header parser, one file byte per beat.
// ----------------------------------------------------------------------------
//
// channel  | dir | payload                                   | beat
// ---------+-----+-------------------------------------------+-----------------
// in_ch    | in  | start_of_file, data_byte, total_length    | one file byte
// out_ch   | out | status, header fields, pcm_offset/size    | one per file
//
// one byte per cycle while in_ch.ready is high: each beat's next parser state
// is combinational (33-bit add and compare on the chunk position is the path)
// a result lands in a two-entry output buffer in the cycle after its byte;
// in_ch.ready drops only while both buffer entries are occupied
// reset (synchronous, active low) returns to idle with an empty buffer;
// bytes are ignored until a start beat
// a start beat in mid-file abandons the file in progress without a result
//
module wav_header_parser
  import whp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  whp_in_if.sink    in_ch,
  whp_out_if.source out_ch
);

  // parser state
  phase_t           phase_r,    phase_nxt;
  logic [POS_W-1:0] pos_r,      pos_nxt;     // byte position in file
  logic [POS_W-1:0] nhp_r,      nhp_nxt;     // next chunk header position
  logic [31:0]      len_m8_r,   len_m8_nxt;  // file length less one header
  logic [31:0]      word_r,     word_nxt;    // little-endian word assembler
  logic [31:0]      tag_r,      tag_nxt;
  logic [31:0]      riff_r,     riff_nxt;
  logic [31:0]      fmt_r,      fmt_nxt;
  logic [15:0]      chan_r,     chan_nxt;
  logic [31:0]      rate_r,     rate_nxt;
  logic [31:0]      brate_r,    brate_nxt;
  logic [15:0]      align_r,    align_nxt;
  logic [15:0]      bits_r,     bits_nxt;

  logic             accept;
  logic             in_ready;
  logic             go;          // byte takes part in parsing
  logic             emit;
  status_t          emit_status;
  logic [31:0]      emit_offset;
  logic [31:0]      emit_size;
  result_t          result;

  // chunk walk helpers
  logic [POS_W-1:0] chk_dist;
  logic [POS_W-1:0] nhp_walk;
  logic [POS_W-1:0] nhp_fmt;
  logic             fmt_skip;

  assign accept      = in_ch.valid & in_ready;
  assign in_ch.ready = in_ready;

  assign chk_dist = pos_r - nhp_r;
  assign fmt_skip = (fmt_r >= FMT_BASE) && (fmt_r < FMT_LIMIT);
  assign nhp_fmt  = fmt_skip ? (POS_W'(fmt_r[5:0]) + FMT_END_BIAS) : FMT_END;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    nhp_nxt     = nhp_r;
    len_m8_nxt  = len_m8_r;
    word_nxt    = word_r;
    tag_nxt     = tag_r;
    riff_nxt    = riff_r;
    fmt_nxt     = fmt_r;
    chan_nxt    = chan_r;
    rate_nxt    = rate_r;
    brate_nxt   = brate_r;
    align_nxt   = align_r;
    bits_nxt    = bits_r;
    go          = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_offset = '0;
    emit_size   = '0;
    nhp_walk    = nhp_r + POS_W'(HDR_BYTES) + POS_W'(word_nxt);

    if (accept) begin
      if (in_ch.start_of_file) begin
        // fresh file: clear everything captured so far
        word_nxt   = '0;
        tag_nxt    = '0;
        riff_nxt   = '0;
        fmt_nxt    = '0;
        chan_nxt   = '0;
        rate_nxt   = '0;
        brate_nxt  = '0;
        align_nxt  = '0;
        bits_nxt   = '0;
        pos_nxt    = '0;
        nhp_nxt    = '0;
        len_m8_nxt = in_ch.total_length - HDR_BYTES;
        if (in_ch.total_length < MIN_LENGTH) begin
          emit        = 1'b1;
          emit_status = ST_TOO_SHORT;
          phase_nxt   = PH_IDLE;
        end else begin
          phase_nxt = PH_HEADER;
          go        = 1'b1;
        end
      end else if (phase_r != PH_IDLE) begin
        pos_nxt = pos_r + POS_W'(1);
        go      = 1'b1;
      end
    end

    if (go) begin
      word_nxt = {in_ch.data_byte, word_nxt[31:8]};
      nhp_walk = nhp_r + POS_W'(HDR_BYTES) + POS_W'(word_nxt);

      if (phase_nxt == PH_HEADER) begin
        // fixed RIFF header and fmt body
        case (pos_nxt)
          OFS_RIFF_TAG:  tag_nxt  = word_nxt;
          OFS_RIFF_SIZE: riff_nxt = word_nxt;
          OFS_WAVE: begin
            if (tag_r != TAG_RIFF || word_nxt != TAG_WAVE) begin
              emit        = 1'b1;
              emit_status = ST_UNSUPP;
            end
          end
          OFS_FMT_TAG:   tag_nxt  = word_nxt;
          OFS_FMT_SIZE:  fmt_nxt  = word_nxt;
          OFS_AUDIO_FMT: begin
            // non-pcm format spoils the fmt tag so it fails below
            if (word_nxt[31:16] != FMT_PCM) begin
              tag_nxt = '0;
            end
          end
          OFS_CHANNELS:  chan_nxt  = word_nxt[31:16];
          OFS_RATE:      rate_nxt  = word_nxt;
          OFS_BYTE_RATE: brate_nxt = word_nxt;
          OFS_ALIGN:     align_nxt = word_nxt[31:16];
          OFS_BITS: begin
            bits_nxt = word_nxt[31:16];
            if (tag_r != TAG_FMT) begin
              emit        = 1'b1;
              emit_status = ST_UNSUPP;
            end else begin
              nhp_nxt = nhp_fmt;
              if (nhp_fmt >= POS_W'(len_m8_r)) begin
                emit        = 1'b1;
                emit_status = ST_NOT_FOUND;
              end else begin
                phase_nxt = PH_CHUNKS;
              end
            end
          end
          default: ;
        endcase
      end else begin
        // chunk walk: read tag and size at each header, skip the body
        if (chk_dist == CHK_TAG_DIST) begin
          tag_nxt = word_nxt;
        end else if (chk_dist == CHK_SIZE_DIST) begin
          if (tag_r == TAG_DATA) begin
            emit        = 1'b1;
            emit_status = ST_OK;
            emit_offset = nhp_r[31:0] + HDR_BYTES;
            emit_size   = word_nxt;
          end else begin
            nhp_nxt = nhp_walk;
            if (nhp_walk >= POS_W'(len_m8_r)) begin
              emit        = 1'b1;
              emit_status = ST_NOT_FOUND;
            end
          end
        end
      end

      if (emit) begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_comb begin
    result.status        = emit_status;
    result.riff_size     = riff_nxt;
    result.fmt_size      = fmt_nxt;
    result.chan_count    = chan_nxt;
    result.samp_freq     = rate_nxt;
    result.bytes_per_sec = brate_nxt;
    result.frame_bytes   = align_nxt;
    result.sample_bits   = bits_nxt;
    result.pcm_offset    = emit_offset;
    result.pcm_size      = emit_size;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // datapath state, only meaningful after a start beat
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    nhp_r    <= nhp_nxt;
    len_m8_r <= len_m8_nxt;
    word_r   <= word_nxt;
    tag_r    <= tag_nxt;
    riff_r   <= riff_nxt;
    fmt_r    <= fmt_nxt;
    chan_r   <= chan_nxt;
    rate_r   <= rate_nxt;
    brate_r  <= brate_nxt;
    align_r  <= align_nxt;
    bits_r   <= bits_nxt;
  end

  whp_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (emit),
    .push_data  (result),
    .push_ready (in_ready),
    .out_ch     (out_ch)
  );

  // a result always ends the file
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> phase_r == PH_IDLE)
    else $error("parser not idle after result");

  // a stray byte while idle never makes a result
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_ch.start_of_file && phase_r == PH_IDLE) |-> !emit)
    else $error("result from byte outside a file");

  // the walk only runs while the next header lies inside the file
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CHUNKS |-> (nhp_r < POS_W'(len_m8_r) && nhp_r >= FMT_END))
    else $error("chunk walk past end of file");

  // pcm data never starts inside the fixed header
  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_status == ST_OK) |-> emit_offset >= MIN_LENGTH)
    else $error("pcm offset inside header");

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming WAV header parser. Whole files are
// built byte by byte, first from a short table of hand-picked cases, then at
// random, and fed through the byte channel under random idling on both
// sides. A byte-level model of the parser predicts each header result not
// typed in the table; every result is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import whp_pkg::*;

  localparam int ITEMS_TARGET   = 1150;    // beats sent in the whole run, at least
  localparam int DRAIN_CYCLES   = 16;      // result is registered in the cycle after its byte
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_REPORTS    = 40;

  // how a generated file is damaged
  typedef enum logic [1:0] {
    FLAW_NONE,
    FLAW_RIFF,   // riff tag off by one bit
    FLAW_WAVE,   // form type off by one bit
    FLAW_FMT     // fmt tag off by one bit
  } flaw_t;

  // pattern of the header fields
  typedef enum logic [1:0] {
    FILL_ZERO,
    FILL_ONES,
    FILL_RAND
  } fill_t;

  typedef struct {
    bit          fixed_len;   // total_length as given, else built size plus len
    logic [31:0] len;
    flaw_t       flaw;
    logic [31:0] fmt_size;
    logic [15:0] audio_fmt;
    fill_t       fill;
    int          junk;        // chunks ahead of the data chunk
    logic [31:0] junk_size;
    bit          has_data;
    logic [31:0] data_size;
    int          cut;         // bytes sent, 0 for the whole file
    int          stray;       // non-start bytes ahead of the start beat
    bit          typed;       // expected result written in the table
    status_t     typed_status;
    logic [31:0] typed_riff;
  } file_spec_t;

  logic clk;
  logic rst_n;

  whp_in_if  in_ch ();
  whp_out_if out_ch ();

  wav_header_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // parser model state
  phase_t           prs_phase;
  logic [POS_W-1:0] prs_pos;
  logic [POS_W-1:0] prs_next;
  logic [31:0]      prs_len;
  logic [31:0]      prs_word;
  logic [31:0]      prs_tag;
  result_t          prs_fields;
  bit               prs_done;
  result_t          prs_out;

  result_t    pending_headers[$];
  logic [7:0] stream[$];
  file_spec_t plan[$];

  bit      typed_on;
  result_t typed_header;

  int sender_idle_pct;
  int receiver_idle_pct;
  int items_sent;
  int bytes_parsed;
  int files_played;
  int headers_seen;
  int mismatches;
  int status_count[4];
  int cycles;

  // --------------------------------------------------------------------------
  // parser model
  // --------------------------------------------------------------------------

  // next chunk header would not fit before the end of the file
  function automatic bit hdr_past_end();
    return prs_next >= POS_W'(prs_len) - POS_W'(8);
  endfunction

  function automatic void close_file(input status_t st, input logic [31:0] ofs,
                                     input logic [31:0] size);
    prs_out            = prs_fields;
    prs_out.status     = st;
    prs_out.pcm_offset = ofs;
    prs_out.pcm_size   = size;
    prs_done           = 1'b1;
    prs_phase          = PH_IDLE;
  endfunction

  // one accepted beat; took is low when the parser ignores the byte
  task automatic parse_byte(input logic sof, input logic [7:0] b, input logic [31:0] len,
                            output bit took);
    logic [POS_W-1:0] hdr_dist;
    took     = 1'b1;
    prs_done = 1'b0;
    if (sof) begin
      prs_fields = '0;
      prs_word   = '0;
      prs_tag    = '0;
      prs_len    = len;
      prs_pos    = '0;
      prs_next   = '0;
      if (len < MIN_LENGTH) begin
        close_file(ST_TOO_SHORT, '0, '0);
        return;
      end
      prs_phase = PH_HEADER;
    end else if (prs_phase == PH_IDLE) begin
      took = 1'b0;
      return;
    end else begin
      prs_pos = prs_pos + POS_W'(1);
    end

    // little-endian word, newest byte on top
    prs_word = {b, prs_word[31:8]};

    if (prs_phase == PH_HEADER) begin
      case (prs_pos)
        OFS_RIFF_TAG:  prs_tag = prs_word;
        OFS_RIFF_SIZE: prs_fields.riff_size = prs_word;
        OFS_WAVE: begin
          if (prs_tag != TAG_RIFF || prs_word != TAG_WAVE) close_file(ST_UNSUPP, '0, '0);
        end
        OFS_FMT_TAG:   prs_tag = prs_word;
        OFS_FMT_SIZE:  prs_fields.fmt_size = prs_word;
        OFS_AUDIO_FMT: begin
          // a non-pcm format spoils the fmt tag so the check below fails
          if (prs_word[31:16] != FMT_PCM) prs_tag = '0;
        end
        OFS_CHANNELS:  prs_fields.chan_count = prs_word[31:16];
        OFS_RATE:      prs_fields.samp_freq = prs_word;
        OFS_BYTE_RATE: prs_fields.bytes_per_sec = prs_word;
        OFS_ALIGN:     prs_fields.frame_bytes = prs_word[31:16];
        OFS_BITS: begin
          prs_fields.sample_bits = prs_word[31:16];
          if (prs_tag != TAG_FMT) begin
            close_file(ST_UNSUPP, '0, '0);
          end else begin
            // first chunk header right after the fmt body, extra bytes only
            // skipped for sane fmt sizes
            prs_next = POS_W'(36);
            if (prs_fields.fmt_size >= FMT_BASE && prs_fields.fmt_size < FMT_LIMIT) begin
              prs_next = prs_next + POS_W'(prs_fields.fmt_size - FMT_BASE);
            end
            if (hdr_past_end()) close_file(ST_NOT_FOUND, '0, '0);
            else prs_phase = PH_CHUNKS;
          end
        end
        default: ;
      endcase
      return;
    end

    // chunk walk: tag then size at the current header position
    if (prs_pos < prs_next) return;
    hdr_dist = prs_pos - prs_next;
    if (hdr_dist == POS_W'(3)) begin
      prs_tag = prs_word;
    end else if (hdr_dist == POS_W'(7)) begin
      if (prs_tag == TAG_DATA) begin
        close_file(ST_OK, 32'(prs_next + POS_W'(8)), prs_word);
      end else begin
        prs_next = prs_next + POS_W'(8) + {1'b0, prs_word};
        if (hdr_past_end()) close_file(ST_NOT_FOUND, '0, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // file building
  // --------------------------------------------------------------------------

  function automatic void put_le(input logic [31:0] w, input int n);
    for (int i = 0; i < n; i++) stream.push_back(w[8*i +: 8]);
  endfunction

  function automatic logic [31:0] fill_val(input fill_t f);
    case (f)
      FILL_ZERO: return '0;
      FILL_ONES: return '1;
      default:   return $urandom;
    endcase
  endfunction

  function automatic file_spec_t row(input bit fixed_len, input logic [31:0] len,
                                     input flaw_t flaw, input logic [31:0] fmt_size,
                                     input logic [15:0] audio_fmt, input fill_t fill,
                                     input int junk, input logic [31:0] junk_size,
                                     input bit has_data, input int cut, input int stray,
                                     input bit typed, input status_t typed_status,
                                     input logic [31:0] typed_riff);
    file_spec_t s;
    s.fixed_len    = fixed_len;
    s.len          = len;
    s.flaw         = flaw;
    s.fmt_size     = fmt_size;
    s.audio_fmt    = audio_fmt;
    s.fill         = fill;
    s.junk         = junk;
    s.junk_size    = junk_size;
    s.has_data     = has_data;
    s.data_size    = $urandom_range(1, 6);
    s.cut          = cut;
    s.stray        = stray;
    s.typed        = typed;
    s.typed_status = typed_status;
    s.typed_riff   = typed_riff;
    return s;
  endfunction

  // mostly well-formed files with random content, the rest damaged or cut
  function automatic file_spec_t random_spec();
    file_spec_t s;
    int pick;
    s = row(0, 0, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_RAND, $urandom_range(0, 3),
            $urandom_range(0, 12), 1, 0, 0, 0, ST_OK, '0);
    pick = $urandom_range(99);
    if (pick < 10) begin
      s.fixed_len = 1;
      s.len       = $urandom_range(0, 43);
      s.cut       = $urandom_range(1, 4);
    end else if (pick < 16) begin
      s.flaw = $urandom_range(1) ? FLAW_RIFF : FLAW_WAVE;
    end else if (pick < 22) begin
      if ($urandom_range(1)) s.flaw = FLAW_FMT;
      else s.audio_fmt = 16'($urandom);
    end else if (pick < 30) begin
      s.cut = $urandom_range(1, 70);
    end

    pick = $urandom_range(99);
    if (pick < 25) s.fmt_size = $urandom_range(16, 63);
    else if (pick < 32) s.fmt_size = $urandom;
    else if (pick < 38) s.fmt_size = $urandom_range(0, 15);

    if (!s.fixed_len) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        s.fixed_len = 1;
        s.len       = $urandom;
      end else if (pick < 18) begin
        s.fixed_len = 1;
        s.len       = $urandom_range(44, 100);
      end else if (pick < 30) begin
        s.len = $urandom_range(0, 8);
      end
    end

    if ($urandom_range(99) < 8) s.junk_size = $urandom;
    if ($urandom_range(99) < 10) s.has_data = 0;
    if ($urandom_range(99) < 20) s.data_size = $urandom;
    else s.data_size = $urandom_range(0, 8);
    pick = $urandom_range(99);
    if (pick < 10) s.fill = FILL_ZERO;
    else if (pick < 20) s.fill = FILL_ONES;
    if ($urandom_range(99) < 15) s.stray = $urandom_range(1, 3);
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // byte channel driver
  // --------------------------------------------------------------------------

  task automatic send_byte(input logic sof, input logic [7:0] b, input logic [31:0] len);
    bit took;
    // idling swaps sides after a third of the run, then stops
    if (items_sent >= 2 * ITEMS_TARGET / 3) begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end else if (items_sent >= ITEMS_TARGET / 3) begin
      sender_idle_pct   = 62;
      receiver_idle_pct = 36;
    end
    // random gap ahead of the beat
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.start_of_file <= sof;
    in_ch.data_byte     <= b;
    in_ch.total_length  <= len;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // beat taken at this edge
    items_sent++;
    parse_byte(sof, b, len, took);
    if (took) bytes_parsed++;
    if (prs_done) begin
      pending_headers.push_back(typed_on ? typed_header : prs_out);
    end
  endtask

  task automatic play_file(input file_spec_t s);
    logic [31:0] riff_tag;
    logic [31:0] wave_tag;
    logic [31:0] fmt_tag;
    logic [31:0] total;
    int          body;
    int          stop;
    riff_tag = TAG_RIFF;
    wave_tag = TAG_WAVE;
    fmt_tag  = TAG_FMT;
    case (s.flaw)
      FLAW_RIFF: riff_tag = riff_tag ^ (32'h1 << $urandom_range(31));
      FLAW_WAVE: wave_tag = wave_tag ^ (32'h1 << $urandom_range(31));
      FLAW_FMT:  fmt_tag  = fmt_tag ^ (32'h1 << $urandom_range(31));
      default: ;
    endcase

    // riff header and fixed fmt body
    stream.delete();
    put_le(riff_tag, 4);
    put_le(fill_val(s.fill), 4);
    put_le(wave_tag, 4);
    put_le(fmt_tag, 4);
    put_le(s.fmt_size, 4);
    put_le(32'(s.audio_fmt), 2);
    put_le(fill_val(s.fill), 2);
    put_le(fill_val(s.fill), 4);
    put_le(fill_val(s.fill), 4);
    put_le(fill_val(s.fill), 2);
    put_le(fill_val(s.fill), 2);
    if (s.fmt_size >= FMT_BASE && s.fmt_size < FMT_LIMIT) begin
      repeat (s.fmt_size - FMT_BASE) put_le($urandom, 1);
    end

    // other chunks; odd low tag byte keeps them from reading as data
    repeat (s.junk) begin
      put_le($urandom | 32'h1, 4);
      put_le(s.junk_size, 4);
      body = (s.junk_size > 32'd12) ? 12 : int'(s.junk_size);
      repeat (body) put_le($urandom, 1);
    end
    if (s.has_data) begin
      put_le(TAG_DATA, 4);
      put_le(s.data_size, 4);
      body = (s.data_size > 32'd8) ? 8 : int'(s.data_size);
      repeat (body) put_le($urandom, 1);
    end

    total = s.fixed_len ? s.len : 32'(stream.size()) + s.len;
    stop  = (s.cut != 0 && s.cut < stream.size()) ? s.cut : stream.size();

    typed_on     = s.typed;
    typed_header = '0;
    typed_header.status    = s.typed_status;
    typed_header.riff_size = s.typed_riff;

    repeat (s.stray) send_byte(1'b0, 8'($urandom), $urandom);
    for (int i = 0; i < stop; i++) begin
      send_byte(i == 0, stream[i], (i == 0) ? total : $urandom);
    end
    typed_on = 1'b0;
    files_played++;
  endtask

  // --------------------------------------------------------------------------
  // clock, receiver stalls, watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_headers.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t ns: %s expected %h got %h", $time, fname, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : result_mon
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status        = status_t'(out_ch.status);
      got.riff_size     = out_ch.riff_size;
      got.fmt_size      = out_ch.fmt_size;
      got.chan_count    = out_ch.chan_count;
      got.samp_freq     = out_ch.samp_freq;
      got.bytes_per_sec = out_ch.bytes_per_sec;
      got.frame_bytes   = out_ch.frame_bytes;
      got.sample_bits   = out_ch.sample_bits;
      got.pcm_offset    = out_ch.pcm_offset;
      got.pcm_size      = out_ch.pcm_size;
      headers_seen++;
      status_count[got.status]++;
      if (pending_headers.size() == 0) begin
        mismatches++;
        $display("%0t ns: header result with nothing expected, status %0d", $time,
                 got.status);
      end else begin
        want = pending_headers.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("riff_size", want.riff_size, got.riff_size);
        check_field("fmt_size", want.fmt_size, got.fmt_size);
        check_field("chan_count", 32'(want.chan_count), 32'(got.chan_count));
        check_field("samp_freq", want.samp_freq, got.samp_freq);
        check_field("bytes_per_sec", want.bytes_per_sec, got.bytes_per_sec);
        check_field("frame_bytes", 32'(want.frame_bytes), 32'(got.frame_bytes));
        check_field("sample_bits", 32'(want.sample_bits), 32'(got.sample_bits));
        check_field("pcm_offset", want.pcm_offset, got.pcm_offset);
        check_field("pcm_size", want.pcm_size, got.pcm_size);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.start_of_file <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.total_length  <= '0;
    rst_n               <= 1'b0;
    prs_phase           = PH_IDLE;
    prs_pos             = '0;
    prs_next            = '0;
    prs_len             = '0;
    prs_word            = '0;
    prs_tag             = '0;
    prs_fields          = '0;
    prs_done            = 1'b0;
    typed_on            = 1'b0;
    sender_idle_pct     = 36;
    receiver_idle_pct   = 62;
    items_sent          = 0;
    cycles              = 0;

    // hand-picked files; typed results only where they are obvious
    //                fix len            flaw       fmt size      audio  fill
    //                junk size          data cut stray  typed result
    plan.push_back(row(1, 32'd0, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_ZERO,
                       0, 0, 1, 3, 2, 1, ST_TOO_SHORT, '0));            // idle bytes, zero length
    plan.push_back(row(1, 32'd43, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_ONES,
                       0, 0, 1, 1, 0, 1, ST_TOO_SHORT, '0));            // one short of minimum
    plan.push_back(row(1, 32'd44, FLAW_RIFF, FMT_BASE, FMT_PCM, FILL_ONES,
                       0, 0, 1, 12, 0, 1, ST_UNSUPP, 32'hFFFF_FFFF));   // bad riff tag
    plan.push_back(row(1, 32'hFFFF_FFFF, FLAW_WAVE, FMT_BASE, FMT_PCM, FILL_ZERO,
                       0, 0, 1, 12, 0, 1, ST_UNSUPP, '0));              // bad form type
    plan.push_back(row(0, 0, FLAW_FMT, FMT_BASE, FMT_PCM, FILL_ONES,
                       0, 0, 1, 36, 0, 0, ST_OK, '0));                  // bad fmt tag
    plan.push_back(row(0, 0, FLAW_NONE, FMT_BASE, 16'h0000, FILL_RAND,
                       0, 0, 1, 36, 0, 0, ST_OK, '0));                  // audio format zero
    plan.push_back(row(0, 0, FLAW_NONE, FMT_BASE, 16'hFFFF, FILL_RAND,
                       0, 0, 1, 36, 0, 0, ST_OK, '0));                  // audio format ones
    plan.push_back(row(1, 32'd44, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_RAND,
                       0, 0, 0, 0, 0, 0, ST_OK, '0));                   // minimum length, no room
    plan.push_back(row(0, 0, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_ZERO,
                       0, 0, 1, 0, 0, 0, ST_OK, '0));                   // shortest good file
    plan.push_back(row(0, 0, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_ONES,
                       0, 0, 1, 0, 0, 0, ST_OK, '0));                   // all-ones fields
    plan.push_back(row(0, 0, FLAW_NONE, 32'd18, FMT_PCM, FILL_RAND,
                       0, 0, 1, 0, 0, 0, ST_OK, '0));                   // extensible fmt
    plan.push_back(row(0, 0, FLAW_NONE, 32'd63, FMT_PCM, FILL_RAND,
                       0, 0, 1, 0, 0, 0, ST_OK, '0));                   // largest skip
    plan.push_back(row(0, 0, FLAW_NONE, FMT_LIMIT, FMT_PCM, FILL_RAND,
                       0, 0, 1, 0, 0, 0, ST_OK, '0));                   // skip limit, no skip
    plan.push_back(row(0, 0, FLAW_NONE, 32'd15, FMT_PCM, FILL_RAND,
                       0, 0, 1, 0, 0, 0, ST_OK, '0));                   // fmt below base
    plan.push_back(row(0, 0, FLAW_NONE, 32'hFFFF_FFFF, FMT_PCM, FILL_RAND,
                       0, 0, 1, 0, 0, 0, ST_OK, '0));                   // fmt size all ones
    plan.push_back(row(0, 0, FLAW_NONE, 32'd0, FMT_PCM, FILL_RAND,
                       0, 0, 1, 0, 0, 0, ST_OK, '0));                   // fmt size zero
    plan.push_back(row(0, 0, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_RAND,
                       2, 5, 1, 0, 0, 0, ST_OK, '0));                   // two chunks before data
    plan.push_back(row(0, 0, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_RAND,
                       1, 0, 1, 0, 0, 0, ST_OK, '0));                   // empty chunk
    plan.push_back(row(1, 32'hFFFF_FFFF, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_RAND,
                       1, 32'hFFFF_FFFF, 1, 0, 0, 0, ST_OK, '0));       // chunk past 32 bits
    plan.push_back(row(0, 0, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_RAND,
                       1, 32'd1000, 1, 0, 0, 0, ST_OK, '0));            // chunk past the end
    plan.push_back(row(0, 0, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_RAND,
                       2, 4, 0, 0, 0, 0, ST_OK, '0));                   // no data chunk
    plan.push_back(row(0, 0, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_RAND,
                       0, 0, 1, 20, 0, 0, ST_OK, '0));                  // cut inside the header
    plan.push_back(row(0, 0, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_RAND,
                       1, 4, 1, 40, 0, 0, ST_OK, '0));                  // cut inside the walk
    plan.push_back(row(1, $urandom | 32'h8000_0000, FLAW_NONE, FMT_BASE, FMT_PCM, FILL_RAND,
                       1, 3, 1, 0, 2, 0, ST_OK, '0));                   // huge declared length

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) play_file(plan[i]);

    // random files until the beat budget is spent
    while (items_sent < ITEMS_TARGET) begin
      play_file(random_spec());
    end
    in_ch.valid <= 1'b0;

    while (pending_headers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d files, %0d beats sent, %0d bytes parsed, %0d header results checked",
             files_played, items_sent, bytes_parsed, headers_seen);
    $display("results by status: ok %0d, too short %0d, unsupported %0d, not found %0d",
             status_count[ST_OK], status_count[ST_TOO_SHORT], status_count[ST_UNSUPP],
             status_count[ST_NOT_FOUND]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
